FILE: hdl/assert_macros.svh
// Assertion macros shared by the matcher RTL.
// Relies on the clk_i and rst_ni names of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define KMPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kmp matcher: assertion failed");

// Condition must never be true at a clock edge outside reset.
`define KMPM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kmp matcher: forbidden condition seen");

`else

`define KMPM_ASSERT(lbl, prop)
`define KMPM_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: hdl/kmpm_pkg.sv
// Package for the KMP stream matcher: sizes, command and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package kmpm_pkg;

  localparam int MAX_PATTERN    = 64;
  localparam int SYMBOL_BITS    = 32;
  localparam int SYMBOL_FIELD_W = 32;
  localparam int SYM_W   = (SYMBOL_BITS < SYMBOL_FIELD_W) ? SYMBOL_BITS : SYMBOL_FIELD_W;
  localparam int PAT_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic       load;          // latch the accepted item
    logic       pat_wr;        // store the symbol at the end of the pattern
    logic       seed_first;    // first pattern symbol: its border is zero
    logic       b_rd_len;      // border read address is length - 1
    logic       s_from_border; // probe index from the border read data
    logic       s_from_prefix; // probe index from the matched prefix
    logic       step;          // compare cycle of one probe
    logic       do_clear;
    logic       do_restart;
    logic       status_we;
    logic [1:0] status;
    logic       out_load;      // move the result into the output register
  } kmpm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_e cmd;       // command of the item in progress
    logic len_zero;  // pattern is empty
    logic pat_full;  // pattern holds MAX_PATTERN symbols
    logic done;      // current probe ends the fall-back walk
  } kmpm_sts_t;

endpackage

FILE: hdl/kmpm_datapath.sv
// Datapath of the KMP matcher: pattern and border memories, probe index,
// match state and the output register. Depends on kmpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmpm_datapath
  import kmpm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kmpm_cmd_t                 cmd_i,
  output kmpm_sts_t                 sts_o,
  input  logic [1:0]                item_cmd_i,
  input  logic [SYMBOL_FIELD_W-1:0] item_sym_i,
  output logic                      match_o,
  output logic                      found_o,
  output logic [1:0]                status_o
);

  // Entry k of the border memory holds border[k+1]; border[0] is the
  // constant minus one and never needs storage.
  logic [SYM_W-1:0]  pat_mem  [MAX_PATTERN];
  logic [PAT_AW-1:0] bord_mem [MAX_PATTERN];

  cmd_e              cmd_q;
  logic [SYM_W-1:0]  sym_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [PAT_AW-1:0] prefix_q, prefix_d;
  logic [PAT_AW-1:0] s_q, s_d;
  logic [PAT_AW-1:0] fb_q, fb_d;   // border of the whole pattern
  logic              found_q, found_d;
  logic              res_match_q, res_match_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              out_match_q, out_found_q;
  logic [1:0]        out_status_q;

  logic [SYM_W-1:0]  pat_rd_q;
  logic [PAT_AW-1:0] bord_rd_q;
  logic [PAT_AW-1:0] b_addr;
  logic [PAT_AW-1:0] len_idx;
  logic              bord_we;
  logic [PAT_AW-1:0] bord_waddr;
  logic [PAT_AW-1:0] bord_wdata;
  logic              hit;
  logic              s_zero;
  logic [LEN_W-1:0]  r;

  assign len_idx = len_q[PAT_AW-1:0];
  assign b_addr  = cmd_i.b_rd_len ? PAT_AW'(len_q - LEN_W'(1)) : PAT_AW'(s_q - PAT_AW'(1));
  assign hit     = (pat_rd_q == sym_q);
  assign s_zero  = (s_q == '0);
  assign r       = hit ? (LEN_W'(s_q) + LEN_W'(1)) : '0;

  assign sts_o.cmd      = cmd_q;
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.pat_full = (len_q >= LEN_W'(MAX_PATTERN));
  assign sts_o.done     = hit || s_zero;

  always_comb begin
    len_d        = len_q;
    prefix_d     = prefix_q;
    s_d          = s_q;
    fb_d         = fb_q;
    found_d      = found_q;
    res_match_d  = res_match_q;
    res_status_d = res_status_q;
    bord_we      = 1'b0;
    bord_waddr   = len_idx;
    bord_wdata   = r[PAT_AW-1:0];

    if (cmd_i.load) begin
      res_match_d  = 1'b0;
      res_status_d = ST_OK;
    end
    if (cmd_i.status_we) begin
      res_status_d = cmd_i.status;
    end
    if (cmd_i.do_clear) begin
      len_d    = '0;
      prefix_d = '0;
      found_d  = 1'b0;
    end
    if (cmd_i.do_restart) begin
      prefix_d = '0;
      found_d  = 1'b0;
    end
    if (cmd_i.seed_first) begin
      bord_we    = 1'b1;
      bord_waddr = '0;
      bord_wdata = '0;
      fb_d       = '0;
      len_d      = LEN_W'(1);
      prefix_d   = '0;
    end
    if (cmd_i.s_from_border) begin
      s_d = bord_rd_q;
    end
    if (cmd_i.s_from_prefix) begin
      s_d = prefix_q;
    end
    if (cmd_i.step) begin
      if (!(hit || s_zero)) begin
        s_d = bord_rd_q;
      end else if (cmd_q == CMD_APPEND) begin
        bord_we  = 1'b1;
        fb_d     = r[PAT_AW-1:0];
        len_d    = len_q + LEN_W'(1);
        prefix_d = '0;
      end else if (r == len_q) begin
        // Full occurrence: continue from the border of the whole pattern.
        res_match_d = 1'b1;
        found_d     = 1'b1;
        prefix_d    = fb_q;
      end else begin
        prefix_d = r[PAT_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pat_rd_q  <= pat_mem[s_q];
    bord_rd_q <= bord_mem[b_addr];
    if (cmd_i.pat_wr) begin
      pat_mem[len_idx] <= sym_q;
    end
    if (bord_we) begin
      bord_mem[bord_waddr] <= bord_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(item_cmd_i);
      sym_q <= item_sym_i[SYM_W-1:0];
    end
    s_q <= s_d;
    if (cmd_i.out_load) begin
      out_match_q  <= res_match_q;
      out_found_q  <= found_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      prefix_q     <= '0;
      fb_q         <= '0;
      found_q      <= 1'b0;
      res_match_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      len_q        <= len_d;
      prefix_q     <= prefix_d;
      fb_q         <= fb_d;
      found_q      <= found_d;
      res_match_q  <= res_match_d;
      res_status_q <= res_status_d;
    end
  end

  assign match_o  = out_match_q;
  assign found_o  = out_found_q;
  assign status_o = out_status_q;

  `KMPM_ASSERT(a_len_in_range, len_q <= LEN_W'(MAX_PATTERN))
  `KMPM_ASSERT(a_prefix_below_len, (len_q != '0) |-> (LEN_W'(prefix_q) < len_q))
  `KMPM_ASSERT(a_border_below_len, (len_q != '0) |-> (LEN_W'(fb_q) < len_q))
  `KMPM_ASSERT(a_match_sets_found, res_match_q |-> found_q)

endmodule

FILE: hdl/kmpm_ctrl.sv
// Controller of the KMP matcher: sequences one transaction through decode,
// border-table probes and result hand-off. Depends on kmpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmpm_ctrl
  import kmpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  kmpm_sts_t sts_i,
  output kmpm_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_BLOAD  = 3'd2;
  localparam logic [2:0] S_LOOK   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.cmd)
          CMD_CLEAR: begin
            cmd_o.do_clear = 1'b1;
            state_d        = S_DONE;
          end
          CMD_RESTART: begin
            cmd_o.do_restart = 1'b1;
            state_d          = S_DONE;
          end
          CMD_APPEND: begin
            if (sts_i.pat_full) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = ST_FULL;
              state_d         = S_DONE;
            end else if (sts_i.len_zero) begin
              cmd_o.pat_wr     = 1'b1;
              cmd_o.seed_first = 1'b1;
              state_d          = S_DONE;
            end else begin
              cmd_o.pat_wr   = 1'b1;
              cmd_o.b_rd_len = 1'b1;
              state_d        = S_BLOAD;
            end
          end
          CMD_TEXT: begin
            if (sts_i.len_zero) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = ST_EMPTY;
              state_d         = S_DONE;
            end else begin
              cmd_o.s_from_prefix = 1'b1;
              state_d             = S_LOOK;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_BLOAD: begin
        cmd_o.s_from_border = 1'b1;
        state_d             = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.done ? S_DONE : S_LOOK;
      end
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `KMPM_ASSERT(a_accept_to_decode, accept |=> (state_q == S_DECODE))
  `KMPM_ASSERT(a_load_sets_valid, cmd_o.out_load |=> out_valid_q)
  `KMPM_ASSERT_NEVER(a_probe_no_load, (state_q == S_CMP) && cmd_o.out_load)

endmodule

FILE: hdl/kmp_stream_matcher_top.sv
// Top level of the KMP stream matcher: stream ports around the controller
// and datapath. Depends on kmpm_pkg, kmpm_ctrl and kmpm_datapath.

// The matcher takes one command per input transaction: clear the pattern,
// append a pattern symbol, feed a text symbol, or restart the search. Each
// transaction yields exactly one result transaction carrying the match
// flag, the sticky found flag and a status code. Work is done one
// transaction at a time, and the cost is set by the border-table walk:
// every probe reads the pattern and border memories through their registered
// read ports and compares in the next cycle, in a look and a compare state.
// Clear, restart, a refused append and text fed to an empty pattern go from
// decode straight to the done state, which moves the result into the output
// register and returns to idle. A text symbol runs k probes after decode;
// k averages at most two per text symbol over a stream, while one symbol may
// need up to the current matched length plus one probes. An append first
// fetches the border of the current pattern end in an extra state before its
// probes; the first symbol of a pattern needs no probe. The result sits in
// an output register, so the next transaction is accepted while a finished
// result still waits; only the final hand-off stalls if that register is
// still occupied. The pattern holds at most MAX_PATTERN symbols and an
// append beyond that is refused with the pattern-full status. There is no
// clearing pass after reset: the block is ready as soon as reset ends.

module kmp_stream_matcher_top
  import kmpm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [SYMBOL_FIELD_W-1:0] s_axis_tdata_i,  // [31:0] symbol
  input  logic [1:0]                s_axis_tuser_i,  // [1:0] command
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o   // [0] match_here, [1] found_any,
                                                     // [3:2] status, [7:4] zero
);

  kmpm_cmd_t  dp_cmd;
  kmpm_sts_t  dp_sts;
  logic       match;
  logic       found;
  logic [1:0] status;

  // The controller owns the handshakes; the datapath holds all item state.
  kmpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  kmpm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .item_cmd_i (s_axis_tuser_i),
    .item_sym_i (s_axis_tdata_i),
    .match_o    (match),
    .found_o    (found),
    .status_o   (status)
  );

  // Result fields packed from the lowest bit up, padded to a whole byte.
  assign m_axis_tdata_o = {4'b0000, status, found, match};

endmodule
